// ----- rtl/assf_pkg.sv -----
// Shared types, constants and the exponential fade table for the soft switch fader.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package assf_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 15;
    localparam int POS_W      = 17;
    localparam int LEN_W      = 16;
    localparam int FRAME_W    = 13;
    localparam int FIDX_W     = 12;
    localparam int MODE_W     = 2;
    localparam int FADE_W     = 2;
    localparam int SEL_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Exponential table
    localparam int EXP_DEPTH  = 256;
    localparam int EXP_IDX_W  = 8;

    // Curve divider: 32-bit dividend, four quotient bits per cycle
    localparam int DIV_W      = 32;
    localparam int DIV_STEP   = 4;
    localparam int DIV_ITERS  = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W  = 3;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Apply-gain arithmetic
    localparam int PROD_W  = SAMPLE_W + GAIN_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam int SHIFT_W = SUM_W - GAIN_FRAC;

    localparam logic [GAIN_W-1:0]  GAIN_ONE   = 16'h8000;
    localparam logic [GAIN_W-1:0]  GAIN_ZERO  = 16'h0000;
    localparam logic [DIV_W-1:0]   ROUND_Q15  = 32'd16384;
    localparam logic [POS_W-1:0]   POS_MAX    = '1;
    localparam logic [FRAME_W-1:0] MAX_FRAME  = 13'd4096;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    // Switch modes
    localparam logic [MODE_W-1:0] MODE_ON      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OFF     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ATTACK  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FADEOUT = 2'd3;

    // Fade curves
    localparam logic [FADE_W-1:0] FADE_SHARP  = 2'd0;
    localparam logic [FADE_W-1:0] FADE_LINEAR = 2'd1;
    localparam logic [FADE_W-1:0] FADE_EXP    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd3;

    // Configuration reset values
    localparam logic [FADE_W-1:0]  RST_FADE_MODE = FADE_LINEAR;
    localparam logic [LEN_W-1:0]   RST_TRANS     = 16'd44;
    localparam logic [FRAME_W-1:0] RST_FRAME     = 13'd512;
    localparam logic               RST_START     = 1'b1;

    // Gain source for the applied gain
    localparam logic [SEL_W-1:0] GSEL_ONE   = 2'd0;
    localparam logic [SEL_W-1:0] GSEL_ZERO  = 2'd1;
    localparam logic [SEL_W-1:0] GSEL_CUR   = 2'd2;
    localparam logic [SEL_W-1:0] GSEL_CURVE = 2'd3;

    // Start gain load at a fade start
    localparam logic [SEL_W-1:0] SSEL_KEEP = 2'd0;
    localparam logic [SEL_W-1:0] SSEL_ONE  = 2'd1;
    localparam logic [SEL_W-1:0] SSEL_ZERO = 2'd2;
    localparam logic [SEL_W-1:0] SSEL_CUR  = 2'd3;

    typedef struct packed {
        logic [FADE_W-1:0]  fade_mode;
        logic [LEN_W-1:0]   trans;
        logic [FRAME_W-1:0] frame_size;
    } t_cfg;

    // One classified sample as handed from the front to the back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [MODE_W-1:0]          mode;
        logic [SEL_W-1:0]           gsel;
        logic [POS_W-1:0]           x_g;
        logic                       upd;
        logic [POS_W-1:0]           x_u;
        logic [SEL_W-1:0]           ssel;
    } t_job;

    typedef logic [GAIN_W-1:0] t_exp_table [EXP_DEPTH];

    // Zero length acts as one sample
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        eff_len = (len == '0) ? LEN_W'(1) : len;
    endfunction

    // Q1.15 table of exp(-9k/depth): ratio by alternating series in Q32, then repeated products
    function automatic t_exp_table build_exp_table();
        t_exp_table  tbl;
        logic [63:0] step_x;
        logic [63:0] term;
        logic [63:0] ratio;
        logic [63:0] v;
        step_x = (64'd9 << 32) / EXP_DEPTH;
        term   = 64'd1 << 32;
        ratio  = 64'd1 << 32;
        v      = 64'd1 << 31;
        for (int n = 1; n <= 14; n++) begin
            term = ((term * step_x) >> 32) / 64'(n);
            if ((n % 2) == 1) begin
                ratio = ratio - term;
            end else begin
                ratio = ratio + term;
            end
        end
        for (int k = 0; k < EXP_DEPTH; k++) begin
            tbl[k] = GAIN_W'((v + 64'd32768) >> 16);
            v      = (v * ratio) >> 32;
        end
        return tbl;
    endfunction

    localparam t_exp_table EXP_TABLE = build_exp_table();

endpackage

// ----- rtl/assf_curve.sv -----
// Fade curve unit: sharp, linear or exponential fadeout value for one position.
// Shares one 16x16 multiplier and a four-bit-per-cycle divider; uses assf_pkg.
`timescale 1ns / 1ps

module assf_curve import assf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_start,
    input  logic [POS_W-1:0]  i_x,
    input  logic [GAIN_W-1:0] i_amp,
    output logic              o_done,
    output logic [GAIN_W-1:0] o_res
);

    localparam logic [2:0] C_IDLE   = 3'd0;
    localparam logic [2:0] C_MUL    = 3'd1;
    localparam logic [2:0] C_DIV    = 3'd2;
    localparam logic [2:0] C_IDX    = 3'd3;
    localparam logic [2:0] C_EXPMUL = 3'd4;
    localparam logic [2:0] C_DONE   = 3'd5;

    logic [2:0]           r_state, n_state;
    logic                 r_exp, n_exp;
    logic [GAIN_W-1:0]    r_amp, n_amp;
    logic [LEN_W-1:0]     r_opb, n_opb;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [LEN_W-1:0]     r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [GAIN_W-1:0]    r_res, n_res;

    logic [LEN_W-1:0]     w_len;
    logic [DIV_W-1:0]     w_prod;
    logic [DIV_W-1:0]     w_round;
    logic [DIV_W-1:0]     w_quo;
    logic [LEN_W-1:0]     w_rem;
    logic [LEN_W:0]       w_trial;
    logic [EXP_IDX_W-1:0] w_idx;

    assign w_len   = eff_len(i_cfg.trans);
    assign w_prod  = DIV_W'(r_amp) * DIV_W'(r_opb);
    assign w_round = w_prod + ROUND_Q15;
    assign w_idx   = (r_quo[DIV_W-1:EXP_IDX_W] != '0) ? '1 : r_quo[EXP_IDX_W-1:0];

    // Restoring division, several quotient bits per cycle
    always_comb begin
        w_quo   = r_quo;
        w_rem   = r_rem;
        w_trial = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            w_trial = {w_rem, w_quo[DIV_W-1]};
            w_quo   = {w_quo[DIV_W-2:0], 1'b0};
            if (w_trial >= {1'b0, w_len}) begin
                w_rem    = LEN_W'(w_trial - {1'b0, w_len});
                w_quo[0] = 1'b1;
            end else begin
                w_rem = w_trial[LEN_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_exp   = r_exp;
        n_amp   = r_amp;
        n_opb   = r_opb;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_res   = r_res;
        case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_amp = i_amp;
                    n_rem = '0;
                    n_cnt = '0;
                    if (((i_cfg.fade_mode != FADE_LINEAR) && (i_cfg.fade_mode != FADE_EXP))
                        || (i_x > {1'b0, w_len})) begin
                        n_res   = GAIN_ZERO;
                        n_state = C_DONE;
                    end else if (i_cfg.fade_mode == FADE_LINEAR) begin
                        n_exp   = 1'b0;
                        n_opb   = w_len - i_x[LEN_W-1:0];
                        n_state = C_MUL;
                    end else begin
                        n_exp   = 1'b1;
                        n_quo   = DIV_W'({i_x[LEN_W-1:0], {EXP_IDX_W{1'b0}}});
                        n_state = C_DIV;
                    end
                end
            end
            C_MUL: begin
                // amp * (len - x) + len / 2, ready for the divide
                n_quo   = w_prod + DIV_W'(w_len >> 1);
                n_state = C_DIV;
            end
            C_DIV: begin
                n_quo = w_quo;
                n_rem = w_rem;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
                    if (r_exp) begin
                        n_state = C_IDX;
                    end else begin
                        n_res   = w_quo[GAIN_W-1:0];
                        n_state = C_DONE;
                    end
                end
            end
            C_IDX: begin
                // saturate the index at the last entry, hold the table value
                n_opb   = EXP_TABLE[w_idx];
                n_state = C_EXPMUL;
            end
            C_EXPMUL: begin
                n_res   = w_round[GAIN_FRAC+GAIN_W-1:GAIN_FRAC];
                n_state = C_DONE;
            end
            C_DONE: begin
                n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_exp <= n_exp;
        r_amp <= n_amp;
        r_opb <= n_opb;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    assign o_done = (r_state == C_DONE);
    assign o_res  = r_res;

endmodule

// ----- rtl/assf_front.sv -----
// Front end: accepts samples, tracks frame index, switch mode and ramp position,
// and classifies each sample into a job for the back end. Uses assf_pkg.
`timescale 1ns / 1ps

module assf_front import assf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_start,
    input  logic                       i_start_en,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic                       i_enable,
    input  logic                       i_full,
    output logic                       o_push,
    output t_job                       o_job
);

    logic [MODE_W-1:0] r_mode, n_mode;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [FIDX_W-1:0] r_fidx, n_fidx;

    logic [FRAME_W-1:0] w_fs;
    logic [FIDX_W-1:0]  w_last_idx;
    logic               w_last;
    logic [LEN_W-1:0]   w_len;
    logic [MODE_W-1:0]  w_mode_a;
    logic [POS_W-1:0]   w_pos_a;
    logic               w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;
    assign w_len    = eff_len(i_cfg.trans);

    always_comb begin
        if (i_cfg.frame_size == '0) begin
            w_fs = FRAME_W'(1);
        end else if (i_cfg.frame_size > MAX_FRAME) begin
            w_fs = MAX_FRAME;
        end else begin
            w_fs = i_cfg.frame_size;
        end
    end

    // an index at or past the last sample ends the frame, also after a shrink
    assign w_last_idx = FIDX_W'(w_fs - 1'b1);
    assign w_last     = (r_fidx >= w_last_idx);

    always_comb begin
        w_mode_a        = r_mode;
        w_pos_a         = r_pos;
        o_job.ssel      = SSEL_KEEP;
        if (r_fidx == '0) begin
            if (((r_mode == MODE_ON) || (r_mode == MODE_ATTACK)) && !i_enable) begin
                o_job.ssel = (r_mode == MODE_ON) ? SSEL_ONE : SSEL_CUR;
                w_pos_a    = '0;
                w_mode_a   = MODE_FADEOUT;
            end else if (((r_mode == MODE_OFF) || (r_mode == MODE_FADEOUT)) && i_enable) begin
                o_job.ssel = (r_mode == MODE_OFF) ? SSEL_ZERO : SSEL_CUR;
                w_pos_a    = '0;
                w_mode_a   = MODE_ATTACK;
            end
        end

        o_job.sample = i_sample_in;
        o_job.mode   = w_mode_a;
        o_job.x_g    = w_pos_a;
        o_job.upd    = 1'b0;
        n_pos        = w_pos_a;
        n_mode       = w_mode_a;
        case (w_mode_a)
            MODE_ON: begin
                o_job.gsel = GSEL_ONE;
            end
            MODE_OFF: begin
                o_job.gsel = GSEL_ZERO;
            end
            default: begin
                if (r_fidx == '0) begin
                    o_job.gsel = GSEL_CUR;
                end else begin
                    o_job.gsel = GSEL_CURVE;
                    if (w_pos_a != POS_MAX) begin
                        n_pos = w_pos_a + 1'b1;
                    end
                end
                if (w_last) begin
                    o_job.upd = 1'b1;
                    if (n_pos > {1'b0, w_len}) begin
                        n_mode = (w_mode_a == MODE_ATTACK) ? MODE_ON : MODE_OFF;
                    end
                end
            end
        endcase
        o_job.x_u = n_pos;
        n_fidx    = w_last ? '0 : r_fidx + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= RST_START ? MODE_ON : MODE_OFF;
            r_pos  <= '0;
            r_fidx <= '0;
        end else if (i_start) begin
            r_mode <= i_start_en ? MODE_ON : MODE_OFF;
            r_pos  <= '0;
            r_fidx <= '0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_fidx <= n_fidx;
        end
    end

endmodule

// ----- rtl/assf_fifo.sv -----
// Short job queue between the front and back ends of the soft switch fader.
// Holds t_job entries from assf_pkg.
`timescale 1ns / 1ps

module assf_fifo import assf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   w_push, w_pop;

    assign o_full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ----- rtl/assf_back.sv -----
// Back end: carries out one job at a time - gain selection, curve evaluation,
// current gain update, multiply, round and saturate. Uses assf_pkg and assf_curve.
`timescale 1ns / 1ps

module assf_back import assf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_start,
    input  logic                       i_start_en,
    input  logic                       i_empty,
    output logic                       o_pop,
    input  t_job                       i_job,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic [GAIN_W-1:0]          o_gain_used,
    output logic [MODE_W-1:0]          o_mode_now
);

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_GAIN  = 3'd1;
    localparam logic [2:0] B_GWAIT = 3'd2;
    localparam logic [2:0] B_UPD   = 3'd3;
    localparam logic [2:0] B_UWAIT = 3'd4;
    localparam logic [2:0] B_MUL   = 3'd5;
    localparam logic [2:0] B_OUT   = 3'd6;

    logic [2:0]                 r_state, n_state;
    t_job                       r_job, n_job;
    logic [GAIN_W-1:0]          r_start_gain, n_start_gain;
    logic [GAIN_W-1:0]          r_cur_gain, n_cur_gain;
    logic [GAIN_W-1:0]          r_g, n_g;
    logic signed [PROD_W-1:0]   r_prod, n_prod;
    logic                       r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample, n_out_sample;
    logic [GAIN_W-1:0]          r_out_gain, n_out_gain;
    logic [MODE_W-1:0]          r_out_mode, n_out_mode;

    logic                       w_curve_start;
    logic [POS_W-1:0]           w_curve_x;
    logic [GAIN_W-1:0]          w_amp;
    logic                       w_curve_done;
    logic [GAIN_W-1:0]          w_curve_res;
    logic [GAIN_W-1:0]          w_ramp;
    logic                       w_attack;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [SHIFT_W-1:0]  w_shift;
    logic signed [SAMPLE_W-1:0] w_sat;

    assign w_attack  = (r_job.mode == MODE_ATTACK);
    // attack runs the fadeout curve on the missing headroom
    assign w_amp     = w_attack ? (GAIN_ONE - r_start_gain) : r_start_gain;
    assign w_ramp    = w_attack ? (GAIN_ONE - w_curve_res) : w_curve_res;
    assign w_curve_x = (r_state == B_GAIN) ? r_job.x_g : r_job.x_u;

    assf_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_start (w_curve_start),
        .i_x     (w_curve_x),
        .i_amp   (w_amp),
        .o_done  (w_curve_done),
        .o_res   (w_curve_res)
    );

    // round half up, floor shift, clamp to the sample range
    assign w_sum   = SUM_W'(r_prod) + SUM_W'($signed(ROUND_Q15));
    assign w_shift = $signed(w_sum[SUM_W-1:GAIN_FRAC]);

    always_comb begin
        if (w_shift > SHIFT_W'(SAMPLE_MAX)) begin
            w_sat = SAMPLE_MAX;
        end else if (w_shift < SHIFT_W'(SAMPLE_MIN)) begin
            w_sat = SAMPLE_MIN;
        end else begin
            w_sat = w_shift[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_job         = r_job;
        n_start_gain  = r_start_gain;
        n_cur_gain    = r_cur_gain;
        n_g           = r_g;
        n_prod        = r_prod;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_sample  = r_out_sample;
        n_out_gain    = r_out_gain;
        n_out_mode    = r_out_mode;
        o_pop         = 1'b0;
        w_curve_start = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_state = B_GAIN;
                    case (i_job.ssel)
                        SSEL_ONE:  n_start_gain = GAIN_ONE;
                        SSEL_ZERO: n_start_gain = GAIN_ZERO;
                        SSEL_CUR:  n_start_gain = r_cur_gain;
                        default:   n_start_gain = r_start_gain;
                    endcase
                end
            end
            B_GAIN: begin
                case (r_job.gsel)
                    GSEL_ONE: begin
                        n_g     = GAIN_ONE;
                        n_state = B_UPD;
                    end
                    GSEL_ZERO: begin
                        n_g     = GAIN_ZERO;
                        n_state = B_UPD;
                    end
                    GSEL_CUR: begin
                        n_g     = r_cur_gain;
                        n_state = B_UPD;
                    end
                    default: begin
                        w_curve_start = 1'b1;
                        n_state       = B_GWAIT;
                    end
                endcase
            end
            B_GWAIT: begin
                if (w_curve_done) begin
                    n_g     = w_ramp;
                    n_state = B_UPD;
                end
            end
            B_UPD: begin
                if (r_job.upd) begin
                    w_curve_start = 1'b1;
                    n_state       = B_UWAIT;
                end else begin
                    n_state = B_MUL;
                end
            end
            B_UWAIT: begin
                if (w_curve_done) begin
                    n_cur_gain = w_ramp;
                    n_state    = B_MUL;
                end
            end
            B_MUL: begin
                n_prod  = PROD_W'(r_job.sample * $signed({1'b0, r_g}));
                n_state = B_OUT;
            end
            B_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = w_sat;
                    n_out_gain   = r_g;
                    n_out_mode   = r_job.mode;
                    n_state      = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_out_valid  <= 1'b0;
            r_start_gain <= RST_START ? GAIN_ONE : GAIN_ZERO;
            r_cur_gain   <= RST_START ? GAIN_ONE : GAIN_ZERO;
        end else if (i_start) begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_start_gain <= i_start_en ? GAIN_ONE : GAIN_ZERO;
            r_cur_gain   <= i_start_en ? GAIN_ONE : GAIN_ZERO;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_start_gain <= n_start_gain;
            r_cur_gain   <= n_cur_gain;
        end
        r_job        <= n_job;
        r_g          <= n_g;
        r_prod       <= n_prod;
        r_out_sample <= n_out_sample;
        r_out_gain   <= n_out_gain;
        r_out_mode   <= n_out_mode;
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_gain_used  = r_out_gain;
    assign o_mode_now   = r_out_mode;

endmodule

// ----- rtl/audio_soft_switch_fader_core.sv -----
// Top level of the soft switch fader: configuration registers, front end,
// job queue and back end. Uses assf_pkg, assf_front, assf_fifo and assf_back.
`timescale 1ns / 1ps

// Click-free audio gate. Each transaction on the input carries one signed 16-bit
// sample and an enable request; the request is only looked at on the first sample
// of each frame, and a change starts a fade in or fade out over transition_samples
// samples (sharp, linear or exponential curve). Every input gives exactly one
// output: the sample times the Q1.15 gain, rounded and saturated, with the gain
// and the mode it was handled in. The front end takes a sample whenever the queue
// has room and hands it through a two-entry queue to the back end, which handles
// one sample at a time; on the last sample of a frame during a fade it works out
// the gain for the next frame as well. The curve unit's divider yields four
// quotient bits per cycle over a 32-bit dividend. Configuration writes are always
// ready; writing enabled_at_start restarts the gate in the on or off mode. No
// clearing pass is needed after reset.

module audio_soft_switch_fader_core import assf_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [SAMPLE_W-1:0]  i_sample_in,
    input  logic                        i_enable,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [SAMPLE_W-1:0]  o_sample_out,
    output logic [GAIN_W-1:0]           o_gain_used,
    output logic [MODE_W-1:0]           o_mode_now,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    logic [FADE_W-1:0]  r_fade_mode;
    logic [LEN_W-1:0]   r_trans;
    logic [FRAME_W-1:0] r_frame_size;

    t_cfg w_cfg;
    logic w_start;
    logic w_start_en;
    logic w_push, w_pop, w_full, w_empty;
    t_job w_job_in, w_job_out;

    assign o_cfg_ready      = 1'b1;
    assign w_start          = i_cfg_valid && (i_cfg_index == CFG_START);
    assign w_start_en       = i_cfg_data[0];
    assign w_cfg.fade_mode  = r_fade_mode;
    assign w_cfg.trans      = r_trans;
    assign w_cfg.frame_size = r_frame_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_mode  <= RST_FADE_MODE;
            r_trans      <= RST_TRANS;
            r_frame_size <= RST_FRAME;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FADE_MODE: r_fade_mode  <= i_cfg_data[FADE_W-1:0];
                CFG_TRANS:     r_trans      <= i_cfg_data[LEN_W-1:0];
                CFG_FRAME:     r_frame_size <= i_cfg_data[FRAME_W-1:0];
                default:       r_fade_mode  <= r_fade_mode;
            endcase
        end
    end

    assf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_start     (w_start),
        .i_start_en  (w_start_en),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample_in (i_sample_in),
        .i_enable    (i_enable),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_job_in)
    );

    assf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    assf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_start      (w_start),
        .i_start_en   (w_start_en),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .i_job        (w_job_out),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .o_gain_used  (o_gain_used),
        .o_mode_now   (o_mode_now)
    );

endmodule

// ----- tb/tb_assf_checker.sv -----
// Checker for the soft switch fader: watches the sample, result and register channels,
// predicts every result and compares it field by field. Depends on assf_pkg.
`timescale 1ns / 1ps

module tb_assf_checker import assf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_in_sample,
    input  logic                       i_in_enable,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [SAMPLE_W-1:0] i_out_sample,
    input  logic [GAIN_W-1:0]          i_out_gain,
    input  logic [MODE_W-1:0]          i_out_mode,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_checked
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [GAIN_W-1:0]          gain;
        logic [MODE_W-1:0]          mode;
    } t_gated_sample;

    // Register copies
    logic [FADE_W-1:0]  fade_sel;
    logic [LEN_W-1:0]   len_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               start_on;

    // Gate state
    logic [MODE_W-1:0] mode_q;
    logic [POS_W-1:0]  pos_q;
    logic [GAIN_W-1:0] cur_gain_q;
    logic [GAIN_W-1:0] start_gain_q;
    logic [FIDX_W-1:0] idx_q;
    logic [GAIN_W-1:0] exp_tab [EXP_DEPTH];

    t_gated_sample expected_q [$];
    int            mismatch_cnt = 0;
    int            compared_cnt = 0;

    // exp(-9/depth) in Q32 by a truncated alternating series, then powers of it
    initial begin : curve_rom
        longint unsigned step_q32;
        longint unsigned term;
        longint unsigned ratio;
        longint unsigned v;
        step_q32 = (64'd9 << 32) / EXP_DEPTH;
        term     = 64'd1 << 32;
        ratio    = 64'd1 << 32;
        v        = 64'd1 << 31;
        for (int n = 1; n <= 14; n++) begin
            term  = ((term * step_q32) >> 32) / n;
            ratio = (n % 2 == 1) ? ratio - term : ratio + term;
        end
        for (int k = 0; k < EXP_DEPTH; k++) begin
            exp_tab[k] = GAIN_W'((v + 64'd32768) >> 16);
            v          = (v * ratio) >> 32;
        end
    end

    function automatic longint unsigned fade_len();
        return (len_reg == '0) ? 64'd1 : 64'(len_reg);
    endfunction

    function automatic void restart_gate();
        pos_q = '0;
        idx_q = '0;
        if (start_on) begin
            mode_q       = MODE_ON;
            cur_gain_q   = GAIN_ONE;
            start_gain_q = GAIN_ONE;
        end else begin
            mode_q       = MODE_OFF;
            cur_gain_q   = GAIN_ZERO;
            start_gain_q = GAIN_ZERO;
        end
    endfunction

    // Fade-out level of amplitude amp_in at position x; sharp and the unused code give zero
    function automatic logic [GAIN_W-1:0] fade_level(input logic [POS_W-1:0] x,
                                                    input logic [GAIN_W-1:0] amp_in);
        longint unsigned lx;
        longint unsigned ll;
        longint unsigned amp;
        longint unsigned tix;
        longint unsigned lvl;
        lx  = x;
        ll  = fade_len();
        amp = (amp_in > GAIN_ONE) ? GAIN_ONE : amp_in;
        lvl = 0;
        if (fade_sel == FADE_LINEAR && lx <= ll) begin
            lvl = (amp * (ll - lx) + ll / 2) / ll;
        end else if (fade_sel == FADE_EXP && lx <= ll) begin
            tix = lx * EXP_DEPTH / ll;
            if (tix >= EXP_DEPTH) tix = EXP_DEPTH - 1;
            lvl = (amp * exp_tab[tix] + 64'd16384) >> 15;
        end
        return GAIN_W'(lvl);
    endfunction

    // Attack rises by the fade-out of the remaining headroom
    function automatic logic [GAIN_W-1:0] ramp_level(input logic [POS_W-1:0] x);
        logic [GAIN_W-1:0] s;
        s = (start_gain_q > GAIN_ONE) ? GAIN_ONE : start_gain_q;
        if (mode_q == MODE_ATTACK) return GAIN_ONE - fade_level(x, GAIN_ONE - s);
        return fade_level(x, s);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] scale_sample(
            input logic signed [SAMPLE_W-1:0] smp, input logic [GAIN_W-1:0] g);
        longint p;
        p = longint'(smp) * longint'(g) + 16384;
        p = p >>> GAIN_FRAC;
        if (p > SAMPLE_MAX) p = SAMPLE_MAX;
        if (p < SAMPLE_MIN) p = SAMPLE_MIN;
        return SAMPLE_W'(p);
    endfunction

    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FADE_MODE: fade_sel = data[FADE_W-1:0];
            CFG_TRANS:     len_reg = data[LEN_W-1:0];
            CFG_FRAME:     frame_reg = data[FRAME_W-1:0];
            CFG_START: begin
                start_on = data[0];
                restart_gate();
            end
        endcase
    endfunction

    // Advance the gate by one sample and return what it should produce
    function automatic t_gated_sample gate_sample(input logic signed [SAMPLE_W-1:0] smp,
                                                  input logic en);
        int                fs;
        logic [MODE_W-1:0] m;
        logic [GAIN_W-1:0] g;
        logic              last;
        t_gated_sample     r;
        fs = (frame_reg == '0) ? 1 : int'(frame_reg);
        if (fs > MAX_FRAME) fs = MAX_FRAME;

        // enable only counts at a frame start
        if (idx_q == '0) begin
            if ((mode_q == MODE_ON || mode_q == MODE_ATTACK) && !en) begin
                start_gain_q = (mode_q == MODE_ON) ? GAIN_ONE : cur_gain_q;
                pos_q        = '0;
                mode_q       = MODE_FADEOUT;
            end else if ((mode_q == MODE_OFF || mode_q == MODE_FADEOUT) && en) begin
                start_gain_q = (mode_q == MODE_OFF) ? GAIN_ZERO : cur_gain_q;
                pos_q        = '0;
                mode_q       = MODE_ATTACK;
            end
        end

        m    = mode_q;
        last = int'(idx_q) >= fs - 1;
        if (m == MODE_ON) begin
            g = GAIN_ONE;
        end else if (m == MODE_OFF) begin
            g = GAIN_ZERO;
        end else begin
            if (idx_q == '0) begin
                g = cur_gain_q;
            end else begin
                g = ramp_level(pos_q);
                if (pos_q != POS_MAX) pos_q = pos_q + 1'b1;
            end
            // gain for the next frame start; settle once past the length
            if (last) begin
                cur_gain_q = ramp_level(pos_q);
                if (64'(pos_q) > fade_len()) mode_q = (m == MODE_ATTACK) ? MODE_ON : MODE_OFF;
            end
        end
        idx_q = last ? '0 : idx_q + 1'b1;

        r.sample = scale_sample(smp, g);
        r.gain   = g;
        r.mode   = m;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_gated_sample want;
        t_gated_sample got;
        if (!i_rst_n) begin
            fade_sel  = RST_FADE_MODE;
            len_reg   = RST_TRANS;
            frame_reg = RST_FRAME;
            start_on  = RST_START;
            restart_gate();
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready) expected_q.push_back(gate_sample(i_in_sample, i_in_enable));
            if (i_out_valid && i_out_ready) begin
                got.sample = i_out_sample;
                got.gain   = i_out_gain;
                got.mode   = i_out_mode;
                if (expected_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: sample %0d gain %0d mode %0d",
                                 got.sample, got.gain, got.mode);
                end else begin
                    want = expected_q.pop_front();
                    compared_cnt++;
                    if (want.sample !== got.sample || want.gain !== got.gain ||
                        want.mode !== got.mode) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch: expected sample %0d gain %0d mode %0d",
                                     want.sample, want.gain, want.mode);
                            $display("          got      sample %0d gain %0d mode %0d",
                                     got.sample, got.gain, got.mode);
                        end
                    end
                end
            end
        end
        o_pending    <= expected_q.size();
        o_mismatches <= mismatch_cnt;
        o_checked    <= compared_cnt;
    end

endmodule

// ----- tb/tb_audio_soft_switch_fader_core.sv -----
// Top of the soft switch fader testbench: clock, reset, stimulus, receiver, watchdog
// and verdict. Depends on assf_pkg, audio_soft_switch_fader_core and tb_assf_checker.
`timescale 1ns / 1ps

module tb_audio_soft_switch_fader_core;
    import assf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 60;
    localparam int LONG_HOLD      = 300;
    localparam int NO_START       = -1;
    localparam int NEVER          = -1;
    localparam logic [FADE_W-1:0] FADE_UNUSED = 2'd3;

    logic                       i_clk;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       i_enable    = 1'b0;
    logic                       i_ready     = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_FADE_MODE;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;
    logic                       o_ready;
    logic                       o_valid;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic [GAIN_W-1:0]          o_gain_used;
    logic [MODE_W-1:0]          o_mode_now;
    logic                       o_cfg_ready;

    int mismatches;
    int pending;
    int checked;
    int send_idle_pct = 22;
    int recv_idle_pct = 60;
    int hold_left     = 0;
    int samples_sent  = 0;
    int reg_writes    = 0;
    int quiet_cycles  = 0;
    logic en_level    = 1'b1;
    logic signed [SAMPLE_W-1:0] corner_samples [8];

    audio_soft_switch_fader_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample_in  (i_sample_in),
        .i_enable     (i_enable),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .o_gain_used  (o_gain_used),
        .o_mode_now   (o_mode_now),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    tb_assf_checker fader_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_sample  (i_sample_in),
        .i_in_enable  (i_enable),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_sample (o_sample_out),
        .i_out_gain   (o_gain_used),
        .i_out_mode   (o_mode_now),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Called just after a rising edge; returns at the edge that takes the transaction
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic en);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_in <= smp;
        i_enable    <= en;
        do @(posedge i_clk); while (!o_ready);
        samples_sent++;
    endtask

    // Hold the input until every expected result has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
    endtask

    // Unused upper data bits carry noise; the block must drop them
    task automatic configure(input int curve, input int len, input int frame, input int start);
        drain();
        write_reg(CFG_FADE_MODE,
                  CFG_DATA_W'(curve) | CFG_DATA_W'($urandom_range(16383) << FADE_W));
        write_reg(CFG_TRANS, CFG_DATA_W'(len));
        write_reg(CFG_FRAME, CFG_DATA_W'(frame) | CFG_DATA_W'($urandom_range(7) << FRAME_W));
        if (start != NO_START)
            write_reg(CFG_START, CFG_DATA_W'(start) | CFG_DATA_W'($urandom_range(32767) << 1));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(15))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return -16'sd1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Enable holds its level for stretches so fades run to the end; some items are noise
    task automatic run_phase(input int curve, input int len, input int frame, input int start,
                             input int count, input int flip_pct, input int hold_at,
                             input int pause_at);
        logic en;
        configure(curve, len, frame, start);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_left = LONG_HOLD;
            if (n == pause_at) drain();
            if ($urandom_range(99) < flip_pct) en_level = !en_level;
            en = ($urandom_range(9) == 0) ? 1'($urandom_range(1)) : en_level;
            send_sample(pick_sample(), en);
        end
    endtask

    initial begin
        corner_samples = '{SAMPLE_MAX, SAMPLE_MIN, -16'sd1, 16'sd1, 16'sd0,
                           16'sd16384, -16'sd16385, 16'sd12345};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: start in on, first frame start asks for a fade-out
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(-16'sd1, 1'b0);

        // Short linear fade over two-sample frames: out to silence, then back in
        configure(FADE_LINEAR, 3, 2, 1);
        for (int n = 0; n < 20; n++)
            send_sample(corner_samples[n % 8], (n < 10) ? 1'b0 : 1'b1);

        run_phase(FADE_LINEAR, 6, 4, 1, 200, 4, NEVER, NEVER);
        run_phase(FADE_EXP, 10, 3, 0, 200, 3, 80, NEVER);
        run_phase(FADE_SHARP, 5, 5, NO_START, 120, 5, NEVER, NEVER);
        run_phase(FADE_UNUSED, 0, 2, NO_START, 120, 6, NEVER, NEVER);

        send_idle_pct = 60;
        recv_idle_pct = 22;
        run_phase(FADE_EXP, 1, 0, NO_START, 100, 5, NEVER, NEVER);
        run_phase(FADE_LINEAR, 65535, 8191, NO_START, 60, 2, NEVER, NEVER);
        // smaller frame while the index is well past its end
        run_phase(FADE_EXP, 40, 16, NO_START, 250, 1, NEVER, 120);
        run_phase(FADE_LINEAR, 20, 7, 1, 250, 2, NEVER, NEVER);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(FADE_EXP, 64, 12, NO_START, 250, 1, NEVER, NEVER);
        run_phase(FADE_LINEAR, 3, 1, 0, 100, 3, NEVER, NEVER);
        run_phase(FADE_EXP, 255, 9, NO_START, 150, 1, NEVER, NEVER);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d samples, %0d register writes; sharp, linear and exponential fades",
                 samples_sent, reg_writes);
        $display("  over frames of 1 to 4096 samples; %0d results compared, %0d mismatches",
                 checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
